[rtl/core/v3alu_pkg.sv]
`timescale 1ns / 1ps

package v3alu_pkg;

  // Number format and derived widths.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FUNC_W    = 4;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned WIDE_W    = PROD_W + 2;
  localparam int unsigned NUM_W     = DATA_W + FRAC_BITS;
  localparam int unsigned ROOT_W    = PROD_W / 2;

  // Pipeline depth: one stage per root bit, one stage per quotient bit.
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned DIV_STAGES  = NUM_W;
  localparam int unsigned TAIL_STAGES = SQRT_STAGES + DIV_STAGES;
  localparam int unsigned PIPE_LAT    = TAIL_STAGES + 4;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ADD   = 4'd0;
  localparam logic [FUNC_W-1:0] FN_SUB   = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MUL   = 4'd2;
  localparam logic [FUNC_W-1:0] FN_DIV   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_DOT   = 4'd4;
  localparam logic [FUNC_W-1:0] FN_CROSS = 4'd5;
  localparam logic [FUNC_W-1:0] FN_SCALE = 4'd6;
  localparam logic [FUNC_W-1:0] FN_NORM  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_MAG   = 4'd8;

  // One request item.
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] az;
    logic signed [DATA_W-1:0] bx;
    logic signed [DATA_W-1:0] by;
    logic signed [DATA_W-1:0] bz;
    logic signed [DATA_W-1:0] factor;
  } req_t;

  // One result item.
  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic signed [DATA_W-1:0] rz;
    logic signed [DATA_W-1:0] rscalar;
    logic                     zero_divide;
    logic                     saturated;
  } rsp_t;

endpackage

[rtl/core/vec3_fixed_point_alu.sv]
`timescale 1ns / 1ps

// Channel   Direction  Signals                    Transfer
// request   in         start_i, busy_o, req_i     start_i high and busy_o low at a clock edge
// result    out        valid_o, rsp_o             valid_o high for one cycle, always taken
//
// A new item may enter at every clock edge; busy_o stays low.
// Each result leaves in the order its item was taken.
// The path runs through the square-root stages (one root bit per stage)
// followed by the three quotient pipelines (one quotient bit per stage).
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever waits.

module vec3_fixed_point_alu
  import v3alu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output rsp_t rsp_o
);

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              clip;
  } sat_t;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic [2:0][DATA_W-1:0]     a;
    logic [2:0][DATA_W-1:0]     b;
    logic [2:0][PROD_W-1:0]     p0;
    logic [2:0][PROD_W-1:0]     p1;
    logic [2:0][DATA_W:0]       as;
  } s1_t;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [2:0][DATA_W-1:0] rv;
    logic                   vsat;
    logic [DATA_W-1:0]      sv;
    logic                   ssat;
    logic [2:0][DATA_W-1:0] na;
    logic [2:0][DATA_W-1:0] nb;
    logic [2:0]             qneg;
    logic [2:0]             bzero;
    logic [2:0]             apos;
    logic [2:0]             aneg;
    logic [ROOT_W-1:0]      m;
  } car_t;

  typedef struct packed {
    logic [PROD_W-1:0] rad;
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // Clip a wide signed value to the 32-bit range.
  function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
    sat_t                     r;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > hi) begin
      r.val  = hi[DATA_W-1:0];
      r.clip = 1'b1;
    end else if (v < lo) begin
      r.val  = lo[DATA_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[DATA_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // One root bit: bring down two radicand bits and try the next root bit.
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t               r;
    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    r     = s;
    cur   = {s.rem, s.rad[PROD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    diff  = cur - trial;
    if (cur >= trial) begin
      r.rem  = diff[ROOT_W+1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur[ROOT_W+1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    r.rad = {s.rad[PROD_W-3:0], 2'b00};
    return r;
  endfunction

  logic                   in_vld_q;
  req_t                   in_q;
  logic                   s1_vld_q;
  s1_t                    s1_d;
  s1_t                    s1_q;
  car_t                   car_d;
  car_t                   car_fwd;
  logic [PROD_W-1:0]      sq_d;
  logic [TAIL_STAGES:0]   vld_q;
  car_t                   car_q [TAIL_STAGES+1];
  sq_t                    sqs_q [SQRT_STAGES+1];
  logic [2:0][NUM_W-1:0]  quo;
  logic [2:0]             qn;
  logic                   out_vld_q;
  rsp_t                   out_d;
  rsp_t                   out_q;

  // The pipeline takes an item in every cycle.
  assign busy_o = 1'b0;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      s1_vld_q  <= in_vld_q;
      vld_q     <= {vld_q[TAIL_STAGES-1:0], s1_vld_q};
      out_vld_q <= vld_q[TAIL_STAGES];
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= req_i;
    end
  end

  // Stage one: operand selection, the six multipliers and add or subtract.
  always_comb begin
    logic [2:0][DATA_W-1:0]   a;
    logic [2:0][DATA_W-1:0]   b;
    logic [2:0][DATA_W-1:0]   a1;
    logic [2:0][DATA_W-1:0]   a2;
    logic [2:0][DATA_W-1:0]   b1;
    logic [2:0][DATA_W-1:0]   b2;
    logic signed [DATA_W-1:0] x0;
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] y1;
    logic signed [PROD_W-1:0] pr0;
    logic signed [PROD_W-1:0] pr1;
    a  = {in_q.az, in_q.ay, in_q.ax};
    b  = {in_q.bz, in_q.by, in_q.bx};
    a1 = {a[0], a[2], a[1]};
    a2 = {a[1], a[0], a[2]};
    b1 = {b[0], b[2], b[1]};
    b2 = {b[1], b[0], b[2]};
    s1_d.func = in_q.func;
    s1_d.a    = a;
    s1_d.b    = b;
    for (int i = 0; i < 3; i++) begin
      x0 = (in_q.func == FN_CROSS) ? a1[i] : a[i];
      case (in_q.func)
        FN_SCALE: y0 = in_q.factor;
        FN_NORM:  y0 = a[i];
        FN_MAG:   y0 = a[i];
        FN_CROSS: y0 = b2[i];
        default:  y0 = b[i];
      endcase
      x1  = b1[i];
      y1  = a2[i];
      pr0 = x0 * y0;
      pr1 = x1 * y1;
      s1_d.p0[i] = pr0;
      s1_d.p1[i] = pr1;
      if (in_q.func == FN_SUB) begin
        s1_d.as[i] = {a[i][DATA_W-1], a[i]} - {b[i][DATA_W-1], b[i]};
      end else begin
        s1_d.as[i] = {a[i][DATA_W-1], a[i]} + {b[i][DATA_W-1], b[i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Stage two: sums of products, scaling back, clipping and divider operands.
  always_comb begin
    logic signed [WIDE_W-1:0] w0 [3];
    logic signed [WIDE_W-1:0] w1 [3];
    logic signed [WIDE_W-1:0] w;
    logic signed [WIDE_W-1:0] dsum;
    sat_t                     sr;
    logic                     an;
    logic                     bn;
    car_d.func = s1_q.func;
    car_d.vsat = 1'b0;
    car_d.m    = '0;
    for (int i = 0; i < 3; i++) begin
      w0[i] = {{2{s1_q.p0[i][PROD_W-1]}}, s1_q.p0[i]};
      w1[i] = {{2{s1_q.p1[i][PROD_W-1]}}, s1_q.p1[i]};
      case (s1_q.func)
        FN_ADD:   w = {{(WIDE_W-DATA_W-1){s1_q.as[i][DATA_W]}}, s1_q.as[i]};
        FN_SUB:   w = {{(WIDE_W-DATA_W-1){s1_q.as[i][DATA_W]}}, s1_q.as[i]};
        FN_MUL:   w = w0[i] >>> FRAC_BITS;
        FN_SCALE: w = w0[i] >>> FRAC_BITS;
        FN_CROSS: w = (w0[i] - w1[i]) >>> FRAC_BITS;
        default:  w = '0;
      endcase
      sr = sat_wide(w);
      car_d.rv[i] = sr.val;
      car_d.vsat  = car_d.vsat | sr.clip;
      an = s1_q.a[i][DATA_W-1];
      bn = s1_q.b[i][DATA_W-1];
      car_d.na[i]    = an ? (DATA_W'(0) - s1_q.a[i]) : s1_q.a[i];
      car_d.nb[i]    = bn ? (DATA_W'(0) - s1_q.b[i]) : s1_q.b[i];
      car_d.qneg[i]  = (s1_q.func == FN_DIV) ? (an ^ bn) : an;
      car_d.bzero[i] = (s1_q.b[i] == '0);
      car_d.aneg[i]  = an;
      car_d.apos[i]  = !an && (s1_q.a[i] != '0);
    end
    dsum = (w0[0] + w0[1] + w0[2]) >>> FRAC_BITS;
    sr   = sat_wide(dsum);
    car_d.sv   = sr.val;
    car_d.ssat = sr.clip;
    sq_d = s1_q.p0[0] + s1_q.p0[1] + s1_q.p0[2];
  end

  // The magnitude joins the carried data once the root is complete.
  always_comb begin
    car_fwd   = car_q[SQRT_STAGES];
    car_fwd.m = sqs_q[SQRT_STAGES].root;
  end

  // Carried data for the square-root and quotient stages.
  always_ff @(posedge clk_i) begin
    car_q[0] <= car_d;
    for (int k = 0; k < TAIL_STAGES; k++) begin
      if (k == SQRT_STAGES) begin
        car_q[k+1] <= car_fwd;
      end else begin
        car_q[k+1] <= car_q[k];
      end
    end
  end

  // Square-root stages on the sum of squares.
  always_ff @(posedge clk_i) begin
    sqs_q[0].rad  <= sq_d;
    sqs_q[0].rem  <= '0;
    sqs_q[0].root <= '0;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      sqs_q[k+1] <= sqrt_step(sqs_q[k]);
    end
  end

  // One quotient pipeline per component; the divisor is b or the magnitude.
  for (genvar g = 0; g < 3; g++) begin : g_div
    v3alu_div_pipe u_div (
      .clk_i (clk_i),
      .num_i ({car_q[SQRT_STAGES].na[g], {FRAC_BITS{1'b0}}}),
      .den_i ((car_q[SQRT_STAGES].func == FN_DIV) ? car_q[SQRT_STAGES].nb[g]
                                                   : sqs_q[SQRT_STAGES].root),
      .neg_i (car_q[SQRT_STAGES].qneg[g]),
      .quo_o (quo[g]),
      .neg_o (qn[g])
    );
  end

  // Final stage: pick each field by operation and gather the flags.
  always_comb begin
    car_t                     c;
    logic [2:0][DATA_W-1:0]   r;
    logic signed [WIDE_W-1:0] qw;
    logic signed [WIDE_W-1:0] mw;
    sat_t                     sr;
    logic                     zd;
    logic                     st;
    c  = car_q[TAIL_STAGES];
    zd = 1'b0;
    st = 1'b0;
    r  = '0;
    for (int i = 0; i < 3; i++) begin
      qw = {{(WIDE_W-NUM_W){1'b0}}, quo[i]};
      if (qn[i]) begin
        qw = -qw;
      end
      sr = sat_wide(qw);
      case (c.func)
        FN_ADD, FN_SUB, FN_MUL, FN_SCALE, FN_CROSS: begin
          r[i] = c.rv[i];
        end
        FN_DIV: begin
          if (c.bzero[i]) begin
            zd = 1'b1;
            st = st | c.apos[i] | c.aneg[i];
            if (c.apos[i]) begin
              r[i] = {1'b0, {(DATA_W-1){1'b1}}};
            end else if (c.aneg[i]) begin
              r[i] = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
              r[i] = '0;
            end
          end else begin
            r[i] = sr.val;
            st   = st | sr.clip;
          end
        end
        FN_NORM: begin
          if (c.m != '0) begin
            r[i] = sr.val;
            st   = st | sr.clip;
          end
        end
        default: r[i] = '0;
      endcase
    end
    case (c.func)
      FN_ADD, FN_SUB, FN_MUL, FN_SCALE, FN_CROSS: st = st | c.vsat;
      FN_NORM: zd = (c.m == '0);
      default: ;
    endcase
    out_d.rx = r[0];
    out_d.ry = r[1];
    out_d.rz = r[2];
    mw = {{(WIDE_W-ROOT_W){1'b0}}, c.m};
    sr = sat_wide(mw);
    case (c.func)
      FN_DOT: begin
        out_d.rscalar = c.sv;
        st            = st | c.ssat;
      end
      FN_MAG: begin
        out_d.rscalar = sr.val;
        st            = st | sr.clip;
      end
      default: out_d.rscalar = '0;
    endcase
    out_d.zero_divide = zd;
    out_d.saturated   = st;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = out_vld_q;
  assign rsp_o   = out_q;

endmodule

[rtl/core/v3alu_div_pipe.sv]
`timescale 1ns / 1ps

module v3alu_div_pipe
  import v3alu_pkg::*;
(
  input  logic              clk_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DATA_W-1:0] den_i,
  input  logic              neg_i,
  output logic [NUM_W-1:0]  quo_o,
  output logic              neg_o
);

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] rem;
    logic [NUM_W-1:0]  quo;
    logic [DATA_W-1:0] den;
    logic              neg;
  } dv_t;

  // One restoring step: bring down a dividend bit and settle one quotient bit.
  function automatic dv_t div_step(input dv_t s);
    dv_t             r;
    logic [DATA_W:0] cur;
    logic [DATA_W:0] diff;
    r    = s;
    cur  = {s.rem, s.num[NUM_W-1]};
    diff = cur - {1'b0, s.den};
    if (cur >= {1'b0, s.den}) begin
      r.rem = diff[DATA_W-1:0];
      r.quo = {s.quo[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = cur[DATA_W-1:0];
      r.quo = {s.quo[NUM_W-2:0], 1'b0};
    end
    r.num = {s.num[NUM_W-2:0], 1'b0};
    return r;
  endfunction

  dv_t st_in;
  dv_t st_q [DIV_STAGES];

  // The first step works straight on the incoming operands.
  always_comb begin
    st_in.num = num_i;
    st_in.rem = '0;
    st_in.quo = '0;
    st_in.den = den_i;
    st_in.neg = neg_i;
  end

  // Quotient stages, one bit each.
  always_ff @(posedge clk_i) begin
    st_q[0] <= div_step(st_in);
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_q[k] <= div_step(st_q[k-1]);
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;
  assign neg_o = st_q[DIV_STAGES-1].neg;

endmodule

[rtl/core/v3alu_checker.sv]
`timescale 1ns / 1ps

module v3alu_checker
  import v3alu_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic valid_o,
  input rsp_t rsp_o
);

  // Every item taken gives a result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##PIPE_LAT valid_o)
    else $error("item taken without a result after the pipeline latency");

  // No result appears without an item taken the same latency before.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, PIPE_LAT))
    else $error("result without a matching item");

  // The zero-divide flag comes only from division or normalize.
  a_zd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.zero_divide) |->
      ($past(req_i.func, PIPE_LAT) == FN_DIV || $past(req_i.func, PIPE_LAT) == FN_NORM))
    else $error("zero-divide flag on an operation that does not divide");

  // An unused operation code gives an all-zero result.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ($past(req_i.func, PIPE_LAT) > FN_MAG)) |-> (rsp_o == '0))
    else $error("unused operation code gave a non-zero result");

endmodule

bind vec3_fixed_point_alu v3alu_checker u_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import v3alu_pkg::*;

  localparam int N_RAND = 1830;
  localparam int FB = FRAC_BITS;
  localparam logic signed [63:0] S_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S_MIN = -64'sd2147483648;
  localparam logic [3:0] FN_SPARE_LO = 4'd9;
  localparam logic [3:0] FN_SPARE_HI = 4'd15;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic valid_o;
  rsp_t rsp_o;

  vec3_fixed_point_alu u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  // Saturate a wide value to 32 bits, noting any clipping.
  function automatic logic signed [31:0] clip32(input logic signed [127:0] v,
                                                inout logic flag);
    if (v > S_MAX) begin
      flag = 1'b1;
      return S_MAX[31:0];
    end
    if (v < S_MIN) begin
      flag = 1'b1;
      return S_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // Floor square root by bit-serial restoring method.
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Work out the result that one request should give.
  function automatic rsp_t alu_result(input req_t q);
    logic signed [127:0] a [3];
    logic signed [127:0] b [3];
    logic signed [127:0] r [3];
    logic signed [127:0] s;
    logic signed [127:0] f;
    logic [63:0] sq;
    logic [63:0] m;
    logic zd, sat, hv, hs;
    rsp_t o;
    a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
    b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
    f = q.factor;
    r[0] = 0; r[1] = 0; r[2] = 0;
    s = 0; zd = 0; sat = 0; hv = 0; hs = 0;
    case (q.func)
      FN_ADD: begin
        for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
        hv = 1;
      end
      FN_SUB: begin
        for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
        hv = 1;
      end
      FN_MUL: begin
        for (int i = 0; i < 3; i++) r[i] = (a[i] * b[i]) >>> FB;
        hv = 1;
      end
      FN_SCALE: begin
        for (int i = 0; i < 3; i++) r[i] = (a[i] * f) >>> FB;
        hv = 1;
      end
      FN_DIV: begin
        // A zero divisor gives a value just outside the range by sign.
        for (int i = 0; i < 3; i++) begin
          if (b[i] == 0) begin
            zd = 1;
            r[i] = a[i] > 0 ? S_MAX + 1 : (a[i] < 0 ? S_MIN - 1 : 0);
          end else begin
            r[i] = (a[i] <<< FB) / b[i];
          end
        end
        hv = 1;
      end
      FN_DOT: begin
        s = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB;
        hs = 1;
      end
      FN_CROSS: begin
        for (int i = 0; i < 3; i++)
          r[i] = (a[(i+1)%3] * b[(i+2)%3] - b[(i+1)%3] * a[(i+2)%3]) >>> FB;
        hv = 1;
      end
      FN_NORM, FN_MAG: begin
        // The square sum wraps at 64 bits as an unsigned sum would.
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + 64'(a[i] * a[i]);
        m = root64(sq);
        if (q.func == FN_MAG) begin
          s = $signed({64'd0, m});
          hs = 1;
        end else begin
          hv = 1;
          if (m == 0) zd = 1;
          else for (int i = 0; i < 3; i++)
            r[i] = (a[i] <<< FB) / $signed({64'd0, m});
        end
      end
      default: ;
    endcase
    o.rx = hv ? clip32(r[0], sat) : '0;
    o.ry = hv ? clip32(r[1], sat) : '0;
    o.rz = hv ? clip32(r[2], sat) : '0;
    o.rscalar = hs ? clip32(s, sat) : '0;
    o.zero_divide = zd;
    o.saturated = sat;
    return o;
  endfunction

  // Holds the results still owed by the block, oldest first.
  class result_board;
    rsp_t owed[$];
    int errors = 0;
    int checked = 0;

    function void note_request(req_t q);
      owed.push_back(alu_result(q));
    endfunction

    function void check_result(rsp_t got);
      rsp_t w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      w = owed.pop_front();
      checked++;
      if (got.rx !== w.rx) begin
        $display("%0t: rx expected %h actual %h", $time, w.rx, got.rx); errors++;
      end
      if (got.ry !== w.ry) begin
        $display("%0t: ry expected %h actual %h", $time, w.ry, got.ry); errors++;
      end
      if (got.rz !== w.rz) begin
        $display("%0t: rz expected %h actual %h", $time, w.rz, got.rz); errors++;
      end
      if (got.rscalar !== w.rscalar) begin
        $display("%0t: rscalar expected %h actual %h", $time, w.rscalar, got.rscalar);
        errors++;
      end
      if (got.zero_divide !== w.zero_divide) begin
        $display("%0t: zero_divide expected %b actual %b", $time, w.zero_divide,
                 got.zero_divide);
        errors++;
      end
      if (got.saturated !== w.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, w.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  result_board board = new();
  bit no_gaps = 0;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Results are always taken, so each strobe is checked at its edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) board.check_result(rsp_o);
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(input req_t q);
    if (!no_gaps) begin
      while ($urandom_range(99) < 33) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_request(q);
  endtask

  // A component value biased towards extremes, zero and small numbers.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(3) << FB;
      4: return -($urandom_range(3) << FB);
      5: return $urandom_range(255) - 128;
      6: return $signed($urandom) >>> $urandom_range(16, 30);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_item();
    req_t q;
    q.func = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    q.ax = pick_value(); q.ay = pick_value(); q.az = pick_value();
    q.bx = pick_value(); q.by = pick_value(); q.bz = pick_value();
    q.factor = pick_value();
    // Divisors are mostly non-zero so the quotient path gets most use.
    if (q.func == FN_DIV && $urandom_range(3) != 0) begin
      if (q.bx == 0) q.bx = 32'h10000;
      if (q.by == 0) q.by = 32'hffff0000;
      if (q.bz == 0) q.bz = 32'h1;
    end
    return q;
  endfunction

  function automatic req_t make_item(input logic [3:0] fn, input logic [31:0] a,
                                     input logic [31:0] b, input logic [31:0] f);
    req_t q;
    q.func = fn;
    q.ax = a; q.ay = a; q.az = a;
    q.bx = b; q.by = b; q.bz = b;
    q.factor = f;
    return q;
  endfunction

  initial begin
    req_t q;
    int waited;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: every operation code at the extremes, and the special cases.
    for (int fn = 0; fn < 9; fn++)
      send_item(make_item(4'(fn), 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_item(make_item(FN_DIV, 32'h00030000, 32'h0, 32'h0));
    send_item(make_item(FN_DIV, 32'hfffd0000, 32'h0, 32'h0));
    send_item(make_item(FN_DIV, 32'h0, 32'h0, 32'h0));
    send_item(make_item(FN_NORM, 32'h0, 32'h0, 32'h0));
    send_item(make_item(FN_MAG, 32'h0, 32'h0, 32'h0));
    send_item(make_item(FN_MAG, 32'h80000000, 32'h0, 32'h0));
    send_item(make_item(FN_NORM, 32'h80000000, 32'h0, 32'h0));
    send_item(make_item(FN_SCALE, 32'h80000000, 32'h0, 32'h80000000));
    send_item(make_item(FN_MUL, 32'hffffffff, 32'h1, 32'h0));
    send_item(make_item(FN_SPARE_LO, 32'h12345678, 32'h1, 32'h1));
    send_item(make_item(FN_SPARE_HI, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    q = make_item(FN_NORM, 32'h00030000, 32'h0, 32'h0);
    q.ay = 32'h00040000; q.az = 32'h0;
    send_item(q);
    start_i <= 1'b0;

    // Pause until everything owed has come back.
    waited = 0;
    while (board.owed.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end

    for (int n = 0; n < N_RAND; n++) begin
      no_gaps = (n >= 600 && n < 900);
      send_item(random_item());
    end
    start_i <= 1'b0;

    waited = 0;
    while (board.owed.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_LAT + 10) @(posedge clk_i);

    $display("Checked %0d results over all nine operations and unused codes,",
             board.checked);
    $display("with saturation, zero divisors and zero vectors included.");
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

[vec3_fixed_point_alu.f]
rtl/core/v3alu_pkg.sv
rtl/core/v3alu_div_pipe.sv
rtl/core/vec3_fixed_point_alu.sv
rtl/core/v3alu_checker.sv
verif/tb_top.sv
